// ----- rtl/hssc_pkg.sv -----
// Package for the Hall six-step commutator: commands, state codes, widths,
// commutation tables and the control/status structs between controller and datapath.
// No dependencies.
package hssc_pkg;

    localparam int HALL_W   = 3;
    localparam int TIME_W   = 32;
    localparam int DUTY_W   = 9;
    localparam int RPM_W    = 13;
    localparam int PCT_W    = 8;
    localparam int PCTC_W   = 7;
    localparam int SPAN_W   = 17;
    localparam int PROD_W   = 23;
    localparam int RECIP_W  = 24;
    localparam int RECIP_SH = 30;
    localparam int MUL_W    = RECIP_SH + DUTY_W;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 48;

    localparam logic [RPM_W-1:0]   RPM_SAT = 13'd5000;
    localparam logic [PCT_W-1:0]   PCT_MAX = 8'd100;
    // ceil(2^30 / 100); exact floor division by 100 for any product below 2^23.
    localparam logic [RECIP_W-1:0] RECIP   = 24'd10737419;

    typedef enum logic [1:0]
    {
        CMD_HALL  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic
    {
        REG_SPEED = 1'b0,
        REG_DIR   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_PREP,
        ST_SPEED_WAIT,
        ST_COMMIT
    } st_t;

    typedef struct packed
    {
        logic capture;
        logic div_start;
        logic latch_duty;
        logic latch_rpm;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic need_duty;
        logic need_speed;
        logic div_done;
        logic out_free;
    } dp_status_t;

    // Phases driven by a Hall code; the same phases get their pins rewritten.
    function automatic logic [2:0] phase_mask(input logic [HALL_W-1:0] code);
        logic [2:0] m;
        case (code)
            3'd1:    m = 3'b101;
            3'd2:    m = 3'b011;
            3'd3:    m = 3'b110;
            3'd4:    m = 3'b110;
            3'd5:    m = 3'b011;
            3'd6:    m = 3'b101;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

    // Pin levels for clockwise rotation.
    function automatic logic [2:0] cw_level(input logic [HALL_W-1:0] code);
        logic [2:0] l;
        case (code)
            3'd1:    l = 3'b001;
            3'd2:    l = 3'b010;
            3'd3:    l = 3'b010;
            3'd4:    l = 3'b100;
            3'd5:    l = 3'b001;
            3'd6:    l = 3'b100;
            default: l = 3'b000;
        endcase
        return l;
    endfunction

endpackage

// ----- rtl/hssc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Uses no package; widths come from its parameters.
module hssc_div #(
    parameter int DVD_W = 23,
    parameter int DVS_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DVD_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        ge        = ~diff[DVS_W];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/hssc_ctrl.sv -----
// Controller state machine of the Hall commutator: sequences capture, the
// duty latch, the speed division and the commit. Depends on hssc_pkg.
module hssc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  hssc_pkg::dp_status_t status,
    output hssc_pkg::ctrl_cmd_t  cmd
);
    import hssc_pkg::*;

    st_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.latch_duty = status.need_duty;
                if (status.need_speed)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_SPEED_WAIT;
                end
                else
                    state_next = ST_COMMIT;
            end
            ST_SPEED_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.latch_rpm = 1'b1;
                    state_next    = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/hssc_dp.sv -----
// Datapath of the Hall commutator: configuration, motor state, duty and speed
// arithmetic around the speed divider, and the output register.
// Depends on hssc_pkg and hssc_div.
module hssc_dp #(
    parameter int DUTY_MIN = 215,
    parameter int DUTY_MAX = 361
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [hssc_pkg::PCT_W-1:0]    cfg_data,
    input  logic [hssc_pkg::IN_W-1:0]     s_tdata,
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hssc_pkg::OUT_W-1:0]    m_tdata,
    input  hssc_pkg::ctrl_cmd_t           cmd,
    output hssc_pkg::dp_status_t          status
);
    import hssc_pkg::*;

    localparam int                SPAN_I   = DUTY_MAX - DUTY_MIN;
    localparam bit                SPAN_NEG = (SPAN_I < 0);
    localparam logic [SPAN_W-1:0] SPAN_MAG = SPAN_W'(SPAN_NEG ? -SPAN_I : SPAN_I);
    localparam logic [DUTY_W-1:0] DUTY_LOW = DUTY_W'(DUTY_MIN);

    logic [PCT_W-1:0]          speed_pct_reg;
    logic                      dir_reg;

    cmd_t                      cmd_reg;
    logic [HALL_W-1:0]         code_reg;
    logic [TIME_W-1:0]         time_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [DUTY_W-1:0]         duty_q_reg;
    logic [RPM_W-1:0]          rpm_q_reg;

    logic [2:0][DUTY_W-1:0]    duty_reg, duty_next;
    logic [2:0]                pin_reg, pin_next;
    logic                      run_reg, run_next;
    logic [TIME_W-1:0]         last_reg, last_next;
    logic [RPM_W-1:0]          rpm_reg, rpm_next;

    logic                      out_valid_reg;
    logic [OUT_W-1:0]          out_data_reg;

    logic [PCTC_W-1:0]         pct_c;
    logic [MUL_W-1:0]          scaled;
    logic [RPM_W-1:0]          div_q;
    logic                      div_done;
    logic [DUTY_W-1:0]         q9;

    logic                      run_after;
    logic [2:0]                mask;
    logic [2:0]                level;
    logic [TIME_W-1:0]         dt;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_pct_reg <= '0;
            dir_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPEED: speed_pct_reg <= cfg_data;
                REG_DIR:   dir_reg       <= cfg_data[0];
                default:   dir_reg       <= dir_reg;
            endcase
        end
    end

    assign pct_c = (speed_pct_reg > PCT_MAX) ? PCT_MAX[PCTC_W-1:0] : speed_pct_reg[PCTC_W-1:0];

    // Item capture and the magnitude of the duty product; its sign is fixed by the span.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= cmd_t'(s_tuser);
            code_reg <= s_tdata[HALL_W-1:0];
            time_reg <= s_tdata[HALL_W +: TIME_W];
            prod_reg <= PROD_W'(pct_c) * PROD_W'(SPAN_MAG);
        end
        if (cmd.latch_duty)
            duty_q_reg <= DUTY_LOW + (SPAN_NEG ? (~q9 + 1'b1) : q9);
        if (cmd.latch_rpm)
            rpm_q_reg <= div_q;
    end

    // Division by 100 as a reciprocal multiplication; only the low quotient bits are kept.
    assign scaled = MUL_W'(prod_reg) * MUL_W'(RECIP);
    assign q9     = DUTY_W'(scaled >> RECIP_SH);

    assign run_after = (cmd_reg == CMD_START) || ((cmd_reg == CMD_HALL) && run_reg);
    assign mask      = phase_mask(code_reg);
    assign level     = cw_level(code_reg) ^ (dir_reg ? mask : 3'b000);
    assign dt        = time_reg - last_reg;

    hssc_div #(
        .DVD_W (RPM_W),
        .DVS_W (TIME_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (RPM_SAT),
        .divisor  (dt),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        duty_next = duty_reg;
        pin_next  = pin_reg;
        run_next  = run_reg;
        last_next = last_reg;
        rpm_next  = rpm_reg;
        if (cmd_reg == CMD_START)
            run_next = 1'b1;
        if (cmd_reg == CMD_STOP)
        begin
            duty_next = '0;
            run_next  = 1'b0;
            rpm_next  = '0;
        end
        if (run_after)
        begin
            if (mask != 3'b000)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    duty_next[i] = mask[i] ? duty_q_reg : '0;
                    pin_next[i]  = mask[i] ? level[i] : pin_reg[i];
                end
            end
            // A zero timestamp marks that no earlier event has been seen.
            if (last_reg != '0)
                rpm_next = (dt == '0) ? RPM_SAT : rpm_q_reg;
            last_next = time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg      <= '0;
            pin_reg       <= '0;
            run_reg       <= 1'b0;
            last_reg      <= '0;
            rpm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                duty_reg      <= duty_next;
                pin_reg       <= pin_next;
                run_reg       <= run_next;
                last_reg      <= last_next;
                rpm_reg       <= rpm_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            out_data_reg <= {4'b0000, rpm_next, run_next, pin_next,
                             duty_next[2], duty_next[1], duty_next[0]};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.need_duty  = run_after && (mask != 3'b000);
    assign status.need_speed = run_after && (last_reg != '0) && (dt != '0);
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || m_tready;

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && cmd_reg == CMD_STOP) |=> (rpm_reg == '0 && !run_reg && duty_reg == '0))
        else $error("stop did not clear speed, duties and run flag");

    a_idle_hall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && cmd_reg == CMD_HALL && !run_reg)
            |=> ($stable(duty_reg) && $stable(pin_reg) && $stable(last_reg)))
        else $error("Hall event while stopped changed motor state");

    a_commit_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (m_tvalid && m_tdata[3*DUTY_W+3] == run_reg
                        && m_tdata[3*DUTY_W+4 +: RPM_W] == rpm_reg))
        else $error("result item does not match committed state");

endmodule

// ----- rtl/hall_six_step_commutator_core.sv -----
// Top level of the Hall six-step commutator: stream ports, configuration port,
// controller and datapath. Depends on hssc_pkg, hssc_ctrl and hssc_dp.
//
// One result item leaves for every input item. Each item passes capture, preparation
// and commit when the speed is not measured (stop, an ignored command, a Hall
// event while stopped, the first event after the zero sentinel, or a zero interval)
// and adds a speed wait before commit when it is, because the speed goes through a
// restoring divider that retires one quotient bit per cycle over 13 steps. The duty
// is formed by a reciprocal multiplication and latched in the preparation state. A
// result that still waits in the output register holds the next commit. A new item
// is taken while the previous result still waits in the output register.
// Configuration writes are taken at any time but belong in idle periods.
module hall_six_step_commutator_core #(
    parameter int DUTY_MIN = 215,
    parameter int DUTY_MAX = 361
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,  // 0 speed_percent, 1 direction
    input  logic [hssc_pkg::PCT_W-1:0] cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [hssc_pkg::IN_W-1:0]  s_tdata,    // hall_code[2:0], time_ms[34:3]
    input  logic [1:0]                 s_tuser,    // command[1:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // duty_a[8:0], duty_b[17:9], duty_c[26:18], pin_a[27], pin_b[28], pin_c[29],
    // running[30], speed_rpm[43:31]
    output logic [hssc_pkg::OUT_W-1:0] m_tdata
);
    import hssc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    hssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hssc_dp #(
        .DUTY_MIN (DUTY_MIN),
        .DUTY_MAX (DUTY_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for hall_six_step_commutator_core: directed table, then random
// Hall sequences under several speed/direction settings, with random stalls on both streams.
// Depends on hssc_pkg and the commutator RTL.
module testbench;
    import hssc_pkg::*;

    localparam int DUTY_MIN    = 215;
    localparam int DUTY_MAX    = 361;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 100;

    // Fields from the highest bit down, as m_tdata carries them.
    typedef struct packed
    {
        logic [RPM_W-1:0]  speed_rpm;
        logic              running;
        logic              pin_c;
        logic              pin_b;
        logic              pin_a;
        logic [DUTY_W-1:0] duty_c;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_a;
    } drive_t;

    typedef struct packed
    {
        logic              is_cfg;
        logic              typed;
        cfg_idx_t          idx;
        logic [PCT_W-1:0]  val;
        cmd_t              cmd;
        logic [HALL_W-1:0] hall;
        logic [TIME_W-1:0] tm;
        drive_t            want;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [PCT_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;

    hall_six_step_commutator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Predictor copy of the commutator state and its registers.
    logic [DUTY_W-1:0] st_duty [3];
    logic              st_pins [3];
    logic              st_run;
    logic [TIME_W-1:0] st_last;
    logic [RPM_W-1:0]  st_rpm;
    logic [PCT_W-1:0]  cfg_pct;
    logic              cfg_dir;

    drive_t expected_drive [$];
    row_t   plan [$];
    int     mismatches;
    int     items_checked;
    int     cycle_count;
    bit     quiet;
    bit     hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void advance_hall(input logic [HALL_W-1:0] hall,
                                         input logic [TIME_W-1:0] now);
        logic [2:0]        drive;
        logic [2:0]        level;
        logic [DUTY_W-1:0] duty;
        logic [TIME_W-1:0] dt;
        int                pct;
        if (!st_run)
            return;
        case (hall)
            3'd1:    begin drive = 3'b101; level = 3'b001; end
            3'd2:    begin drive = 3'b011; level = 3'b010; end
            3'd3:    begin drive = 3'b110; level = 3'b010; end
            3'd4:    begin drive = 3'b110; level = 3'b100; end
            3'd5:    begin drive = 3'b011; level = 3'b001; end
            3'd6:    begin drive = 3'b101; level = 3'b100; end
            default: begin drive = 3'b000; level = 3'b000; end
        endcase
        // Counter-clockwise inverts the rewritten pins.
        if (cfg_dir)
            level = level ^ drive;
        pct  = (cfg_pct > 8'd100) ? 100 : int'(cfg_pct);
        duty = DUTY_W'(DUTY_MIN + (pct * (DUTY_MAX - DUTY_MIN)) / 100);
        if (drive != 3'b000)
        begin
            for (int i = 0; i < 3; i++)
            begin
                st_duty[i] = drive[i] ? duty : '0;
                if (drive[i])
                    st_pins[i] = level[i];
            end
        end
        // A zero last time means no earlier event to measure against.
        if (st_last == '0)
            st_last = now;
        else
        begin
            dt      = now - st_last;
            st_rpm  = (dt == '0) ? RPM_W'(5000) : RPM_W'(32'd5000 / dt);
            st_last = now;
        end
    endfunction

    function automatic drive_t commutate(input cmd_t cmd, input logic [HALL_W-1:0] hall,
                                         input logic [TIME_W-1:0] now);
        drive_t r;
        case (cmd)
            CMD_HALL:  advance_hall(hall, now);
            CMD_START:
            begin
                st_run = 1'b1;
                advance_hall(hall, now);
            end
            CMD_STOP:
            begin
                for (int i = 0; i < 3; i++)
                    st_duty[i] = '0;
                st_run = 1'b0;
                st_rpm = '0;
            end
            default: ;
        endcase
        r.duty_a    = st_duty[0];
        r.duty_b    = st_duty[1];
        r.duty_c    = st_duty[2];
        r.pin_a     = st_pins[0];
        r.pin_b     = st_pins[1];
        r.pin_c     = st_pins[2];
        r.running   = st_run;
        r.speed_rpm = st_rpm;
        return r;
    endfunction

    function automatic drive_t mk_drive(input int da, input int db, input int dc,
                                        input bit pa, input bit pb, input bit pc,
                                        input bit run, input int rpm);
        drive_t r;
        r.duty_a    = DUTY_W'(da);
        r.duty_b    = DUTY_W'(db);
        r.duty_c    = DUTY_W'(dc);
        r.pin_a     = pa;
        r.pin_b     = pb;
        r.pin_c     = pc;
        r.running   = run;
        r.speed_rpm = RPM_W'(rpm);
        return r;
    endfunction

    task automatic note_error(input string msg);
        $display("ERROR item %0d: %s", items_checked, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            note_error($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Output monitor: every accepted item is matched against the oldest prediction.
    always @(posedge clk)
    begin
        drive_t got;
        drive_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = drive_t'(m_tdata[$bits(drive_t)-1:0]);
            if (expected_drive.size() == 0)
                note_error("result item with nothing expected");
            else
            begin
                want = expected_drive.pop_front();
                check_field("duty_a", got.duty_a, want.duty_a);
                check_field("duty_b", got.duty_b, want.duty_b);
                check_field("duty_c", got.duty_c, want.duty_c);
                check_field("pin_a", got.pin_a, want.pin_a);
                check_field("pin_b", got.pin_b, want.pin_b);
                check_field("pin_c", got.pin_c, want.pin_c);
                check_field("running", got.running, want.running);
                check_field("speed_rpm", got.speed_rpm, want.speed_rpm);
            end
            items_checked++;
        end
    end

    // Receiver: random stalls per item, and one long hold-off when asked.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                gap = quiet ? 0 : $urandom_range(0, 5);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Called and returning at a falling edge; predicts at the accepting edge.
    task automatic send_item(input cmd_t cmd, input logic [HALL_W-1:0] hall,
                             input logic [TIME_W-1:0] tm, input bit typed,
                             input drive_t want);
        int     gap;
        drive_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {{(IN_W-TIME_W-HALL_W){1'b0}}, tm, hall};
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = commutate(cmd, hall, tm);
        expected_drive.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_drive.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [PCT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == REG_SPEED)
            cfg_pct = val;
        else
            cfg_dir = val[0];
    endtask

    task automatic add_cfg(input cfg_idx_t idx, input logic [PCT_W-1:0] val);
        row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        plan.push_back(r);
    endtask

    task automatic add_item(input cmd_t cmd, input logic [HALL_W-1:0] hall,
                            input logic [TIME_W-1:0] tm, input bit typed, input drive_t want);
        row_t r;
        r       = '0;
        r.cmd   = cmd;
        r.hall  = hall;
        r.tm    = tm;
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endtask

    initial
    begin
        logic [2:0]        seq [6];
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] tm;
        logic [HALL_W-1:0] hall;
        cmd_t              cmd;
        int                seq_pos;
        int                r;
        int                pct_set [6];
        int                dir_set [6];

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_SPEED;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_HALL;
        m_tready    = 1'b0;
        mismatches  = 0;
        items_checked = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            st_duty[i] = '0;
            st_pins[i] = 1'b0;
        end
        st_run  = 1'b0;
        st_last = '0;
        st_rpm  = '0;
        cfg_pct = '0;
        cfg_dir = 1'b0;
        seq = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

        // Directed part, starting from the reset settings.
        add_item(CMD_HALL, 3'd5, 32'd100, 1, mk_drive(0, 0, 0, 0, 0, 0, 0, 0));
        add_item(CMD_NONE, 3'd3, 32'd7, 1, mk_drive(0, 0, 0, 0, 0, 0, 0, 0));
        add_item(CMD_STOP, 3'd0, 32'd0, 1, mk_drive(0, 0, 0, 0, 0, 0, 0, 0));
        add_item(CMD_START, 3'd0, 32'd0, 1, mk_drive(0, 0, 0, 0, 0, 0, 1, 0));
        add_item(CMD_HALL, 3'd1, 32'd10, 1, mk_drive(215, 0, 215, 1, 0, 0, 1, 0));
        add_item(CMD_HALL, 3'd2, 32'd11, 1, mk_drive(215, 215, 0, 0, 1, 0, 1, 5000));
        add_item(CMD_HALL, 3'd3, 32'd11, 0, '0);
        add_item(CMD_HALL, 3'd7, 32'd20, 0, '0);
        add_item(CMD_HALL, 3'd0, 32'd5020, 0, '0);
        add_item(CMD_HALL, 3'd4, 32'hFFFF_FFFF, 0, '0);
        add_item(CMD_HALL, 3'd6, 32'd3, 0, '0);
        add_cfg(REG_SPEED, 8'd255);
        add_cfg(REG_DIR, 8'd1);
        for (int c = 1; c <= 6; c++)
            add_item(CMD_HALL, HALL_W'(c), TIME_W'(3 + c * c), 0, '0);
        add_cfg(REG_SPEED, 8'd100);
        add_cfg(REG_DIR, 8'd0);
        add_item(CMD_HALL, 3'd5, 32'd100, 0, '0);
        add_cfg(REG_SPEED, 8'd37);
        add_item(CMD_START, 3'd2, 32'd120, 0, '0);
        add_item(CMD_NONE, 3'd1, 32'd130, 0, '0);
        add_item(CMD_STOP, 3'd3, 32'd140, 0, '0);
        add_item(CMD_HALL, 3'd4, 32'd150, 0, '0);
        // Timestamp zero while running rearms the first-event sentinel.
        add_item(CMD_START, 3'd6, 32'd0, 0, '0);
        add_item(CMD_HALL, 3'd3, 32'd500, 0, '0);
        add_item(CMD_HALL, 3'd3, 32'd501, 0, '0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                send_item(plan[i].cmd, plan[i].hall, plan[i].tm, plan[i].typed, plan[i].want);
        end

        // Random part: mostly running Hall sequences with realistic intervals.
        pct_set = '{0, 100, 255, 7, $urandom_range(0, 255), $urandom_range(101, 255)};
        dir_set = '{1, 0, 1, 0, $urandom_range(0, 1), $urandom_range(0, 1)};
        clock_ms = 32'd1000;
        seq_pos  = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            write_reg(REG_SPEED, PCT_W'(pct_set[ph]));
            write_reg(REG_DIR, PCT_W'(dir_set[ph]));
            quiet = (ph == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 3 && n == 10)
                    hold_req = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 3)
                    cmd = CMD_STOP;
                else if (r < 7)
                    cmd = CMD_START;
                else if (r < 10)
                    cmd = CMD_NONE;
                else
                    cmd = CMD_HALL;
                if (!st_run && cmd == CMD_HALL && $urandom_range(0, 3) != 0)
                    cmd = CMD_START;
                if ($urandom_range(0, 4) != 0)
                begin
                    seq_pos = (seq_pos + 1) % 6;
                    hall    = seq[seq_pos];
                end
                else
                    hall = HALL_W'($urandom_range(0, 7));
                r = $urandom_range(0, 99);
                if (r < 60)
                    tm = clock_ms + $urandom_range(1, 20);
                else if (r < 70)
                    tm = clock_ms;
                else if (r < 80)
                    tm = clock_ms + $urandom_range(21, 6000);
                else if (r < 90)
                    tm = $urandom();
                else if (r < 94)
                    tm = '0;
                else
                    tm = clock_ms + $urandom();
                clock_ms = tm;
                send_item(cmd, hall, tm, 0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_drive.size() != 0)
            @(negedge clk);
        repeat (TAIL) @(negedge clk);
        if (mismatches == 0 && expected_drive.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/hssc_pkg.sv
rtl/hssc_div.sv
rtl/hssc_ctrl.sv
rtl/hssc_dp.sv
rtl/hall_six_step_commutator_core.sv
tb/testbench.sv
